@@ hdl/tkh_pkg.sv @@
// shared types, constants and score compare for the top-k heap selector
`default_nettype none

package tkh_pkg;

  localparam int KEEP_W = 4;
  localparam logic [KEEP_W-1:0] KEEP_RESET = 4'd3;

  typedef logic signed [31:0] score_t;
  typedef logic [30:0] id_t;

  typedef struct packed {
    score_t score;
    id_t    item_id;
    logic   set_end;
  } in_item_t;

  typedef struct packed {
    score_t kept_score;
    id_t    kept_id;
    logic   final_entry;
  } out_item_t;

  typedef struct packed {
    score_t score;
    id_t    id;
  } entry_t;

  // full signed compare of two scores
  function automatic logic score_less(input score_t a, input score_t b);
    score_less = (a < b);
  endfunction

endpackage

`default_nettype wire

@@ hdl/tkh_ram.sv @@
// heap entry store: one write port, two registered read ports
`default_nettype none

module tkh_ram
  import tkh_pkg::*;
#(
  parameter int DEPTH = 8,
  parameter int AW = 3
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire entry_t        wr_data,
  input  wire logic [AW-1:0] rd_addr_a,
  input  wire logic [AW-1:0] rd_addr_b,
  output entry_t             rd_data_a,
  output entry_t             rd_data_b
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

`default_nettype wire

@@ hdl/top_k_min_heap_select.sv @@
// top level of the top-k selector: min-heap sequencer around the entry store
//
//  channel      dir  handshake                 payload
//  in           in   in_valid / in_ready       in_data  (score, item_id, set_end)
//  out          out  out_valid / out_ready     out_data (kept_score, kept_id, final_entry)
//  keep_count   in   keep_count_we             keep_count (4 bits)
//
//  operation: one item at a time; each heap level is a read, then a compare and
//    write, in the store; an append sifts up from the end; an item no larger
//    than the root is dropped; a replacement removes the root, sifts the last
//    entry down from the root, then appends the item and sifts it up
//  set end: after the item, the kept entries go out one beat at a time, held while out stalls
//  reset: synchronous, clears the fill count, the output valid and keep_count to 3
//  stalls: in_ready is high only between items; a last beat waiting in the output
//    register does not hold off the next input beat
`default_nettype none

module top_k_min_heap_select
  import tkh_pkg::*;
#(
  parameter int CAPACITY = 8
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire in_item_t          in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output out_item_t              out_data,
  input  wire logic              keep_count_we,
  input  wire logic [KEEP_W-1:0] keep_count
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CW = AW + 2;

  typedef enum logic [3:0] {
    IDLE,
    CHK,
    SD_RD,
    SD_CMP,
    APPEND,
    SU_RD,
    SU_CMP,
    EMIT_RD,
    EMIT_LD
  } state_t;

  state_t            state;
  logic [KEEP_W-1:0] keep_k;
  logic [CNT_W-1:0]  fill;
  logic [AW-1:0]     pos;
  logic [AW-1:0]     emit_idx;
  entry_t            mov;      // entry being sifted, held out of the store
  in_item_t          item;     // beat under work

  logic [CNT_W-1:0]  k_eff;
  logic [CW-1:0]     lc;
  logic [CW-1:0]     rc;
  logic              lc_ok;
  logic              rc_ok;
  logic [AW-1:0]     par;
  logic              take_l;
  logic              take_r;
  logic              emit_last;
  state_t            done_state;

  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  entry_t            wr_data;
  logic [AW-1:0]     rd_addr_a;
  logic [AW-1:0]     rd_addr_b;
  entry_t            rd_a;
  entry_t            rd_b;

  tkh_ram #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_ram (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_a),
    .rd_data_b (rd_b)
  );

  // keep count clamped to 1..CAPACITY
  always_comb begin
    if (keep_k == '0) begin
      k_eff = CNT_W'(1);
    end else if (32'(keep_k) > CAPACITY) begin
      k_eff = CNT_W'(CAPACITY);
    end else begin
      k_eff = CNT_W'(keep_k);
    end
  end

  // heap index arithmetic around the current position
  assign lc    = {1'b0, pos, 1'b1};
  assign rc    = lc + CW'(1);
  assign lc_ok = lc < CW'(fill);
  assign rc_ok = rc < CW'(fill);
  assign par   = AW'((pos - AW'(1)) >> 1);

  // sift-down choice: strictly smaller child wins, left on a tie
  assign take_l = lc_ok && score_less(rd_a.score, mov.score);
  assign take_r = rc_ok && score_less(rd_b.score, take_l ? rd_a.score : mov.score);

  assign emit_last  = (CW'(emit_idx) + CW'(1)) == CW'(fill);
  assign done_state = item.set_end ? EMIT_RD : IDLE;
  assign in_ready   = (state == IDLE);

  // store access per state
  always_comb begin
    wr_en     = 1'b0;
    wr_addr   = pos;
    wr_data   = mov;
    rd_addr_a = '0;
    rd_addr_b = '0;
    unique case (state)
      IDLE: begin
        // root and last entry, ready for the replace check
        rd_addr_b = AW'(fill - CNT_W'(1));
      end
      CHK: begin
      end
      SD_RD: begin
        rd_addr_a = lc[AW-1:0];
        rd_addr_b = rc[AW-1:0];
        if (!lc_ok) begin
          wr_en = 1'b1;
        end
      end
      SD_CMP: begin
        wr_en = 1'b1;
        if (take_r) begin
          wr_data = rd_b;
        end else if (take_l) begin
          wr_data = rd_a;
        end
      end
      APPEND: begin
      end
      SU_RD: begin
        if (pos == '0) begin
          wr_en = 1'b1;
        end else begin
          rd_addr_a = par;
        end
      end
      SU_CMP: begin
        wr_en = 1'b1;
        if (score_less(mov.score, rd_a.score)) begin
          wr_data = rd_a;
        end
      end
      EMIT_RD, EMIT_LD: begin
        rd_addr_a = emit_idx;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      fill      <= '0;
      out_valid <= 1'b0;
      keep_k    <= KEEP_RESET;
    end else begin
      if (keep_count_we) begin
        keep_k <= keep_count;
      end
      // a beat leaving while the next one loads is handled in EMIT_LD
      if (out_valid && out_ready && state != EMIT_LD) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          emit_idx <= '0;
          if (in_valid) begin
            item <= in_data;
            if (fill < k_eff) begin
              // heap not full: append and sift up
              mov   <= '{score: in_data.score, id: in_data.item_id};
              pos   <= AW'(fill);
              fill  <= fill + CNT_W'(1);
              state <= SU_RD;
            end else begin
              state <= CHK;
            end
          end
        end
        CHK: begin
          if (score_less(rd_a.score, item.score)) begin
            // drop the root, last entry takes its place
            fill  <= fill - CNT_W'(1);
            mov   <= rd_b;
            pos   <= '0;
            state <= (fill == CNT_W'(1)) ? APPEND : SD_RD;
          end else begin
            state <= done_state;
          end
        end
        SD_RD: begin
          state <= lc_ok ? SD_CMP : APPEND;
        end
        SD_CMP: begin
          if (take_r) begin
            pos   <= rc[AW-1:0];
            state <= SD_RD;
          end else if (take_l) begin
            pos   <= lc[AW-1:0];
            state <= SD_RD;
          end else begin
            state <= APPEND;
          end
        end
        APPEND: begin
          mov   <= '{score: item.score, id: item.item_id};
          pos   <= AW'(fill);
          fill  <= fill + CNT_W'(1);
          state <= SU_RD;
        end
        SU_RD: begin
          state <= (pos == '0) ? done_state : SU_CMP;
        end
        SU_CMP: begin
          if (score_less(mov.score, rd_a.score)) begin
            pos   <= par;
            state <= SU_RD;
          end else begin
            state <= done_state;
          end
        end
        EMIT_RD: begin
          state <= EMIT_LD;
        end
        EMIT_LD: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            out_data  <= '{kept_score: rd_a.score, kept_id: rd_a.id,
                           final_entry: emit_last};
            if (emit_last) begin
              fill  <= '0;
              state <= IDLE;
            end else begin
              emit_idx <= emit_idx + AW'(1);
              state    <= EMIT_RD;
            end
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  // fill count never passes the store depth
  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    32'(fill) <= CAPACITY)
    else $error("fill count beyond capacity");

  // every store write lands inside the live heap
  a_wr_live: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (CW'(wr_addr) < CW'(fill)))
    else $error("store write outside live entries");

  // emission reads only live entries
  a_emit_live: assert property (@(posedge clk) disable iff (rst)
    (state == EMIT_RD) |-> (CW'(emit_idx) < CW'(fill)))
    else $error("emission index beyond fill");

  // the final beat of a set empties the heap
  a_final_clears: assert property (@(posedge clk) disable iff (rst)
    (state == EMIT_LD && (!out_valid || out_ready) && emit_last)
      |=> (fill == '0 && out_valid && out_data.final_entry))
    else $error("final beat did not clear heap");

endmodule

`default_nettype wire
